/* rtl/fpli_pkg.sv */
// Shared constants, types and helper functions for the float pixel to lookup index block.
package fpli_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned CFG_IDX_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_EN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK    = 8'd3;

    localparam logic [WORD_W-1:0] GAIN_RESET = 32'h3F80_0000;

    // Index limits and blank code
    localparam logic signed [INDEX_W-1:0] INDEX_MIN   = 16'sh8001;
    localparam logic signed [INDEX_W-1:0] INDEX_MAX   = 16'sh7FFF;
    localparam logic signed [INDEX_W-1:0] BLANK_INDEX = 16'sh8000;

    // Class of a binary32 value as it moves down the pipeline
    typedef enum logic [1:0] {
        CL_ZERO,
        CL_FIN,
        CL_INF,
        CL_NAN
    } t_class;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [WORD_W-1:0] offset_bits;
        logic [WORD_W-1:0] gain_bits;
        logic              blank_enable;
        logic [WORD_W-1:0] blank_bits;
    } t_cfg;

    // Count leading zeros of a 28-bit word (28 when all zero)
    function automatic logic [4:0] lzc28(input logic [27:0] x);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found) begin
                if (x[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    // Count leading zeros of a 24-bit word (24 when all zero)
    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (x[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

/* rtl/fpli_pipe.sv */
// Seven-stage datapath: blank check, binary32 add, binary32 multiply, round and saturate.
module fpli_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpli_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fpli_pkg::WORD_W-1:0]         i_pixel_bits,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fpli_pkg::INDEX_W-1:0] o_lut_index
);

    typedef logic signed [10:0] t_exp;

    // Stage payloads
    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        logic             sub;
        logic [7:0]       ef;
        logic [26:0]      ma;
        logic [26:0]      mb;
    } t_s1;

    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        logic [7:0]       ef;
        logic [27:0]      sum;
    } t_s2;

    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        t_exp             e;
        logic [27:0]      norm;
    } t_s3;

    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        t_exp             e;
        logic [23:0]      ms;
        logic [23:0]      mg;
    } t_s4;

    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        t_exp             e;
        logic [47:0]      prod;
    } t_s5;

    typedef struct packed {
        logic             blank;
        fpli_pkg::t_class cls;
        logic             sign;
        t_exp             e;
        logic [23:0]      mant;
    } t_s6;

    logic [7:1] r_v;
    logic [7:1] en;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    logic signed [fpli_pkg::INDEX_W-1:0] r_idx, n_idx;

    // Advance a stage when it is empty or the one after it advances
    always_comb begin
        en[7] = !r_v[7] || i_ready;
        for (int k = 6; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready     = en[1];
    assign o_valid     = r_v[7];
    assign o_lut_index = r_idx;

    // Stage 1: classify, blank check, swap and align the smaller addend
    always_comb begin
        logic       ps, os, bs_nan, px_nan, px_inf, of_nan, of_inf, eq, a_px;
        logic [7:0] pe, oe, ea, eb, efa, efb, d;
        logic [22:0] pf, of;
        logic [23:0] ma, mb;
        logic [26:0] xb, al;
        logic       st;
        ps     = i_pixel_bits[31];
        pe     = i_pixel_bits[30:23];
        pf     = i_pixel_bits[22:0];
        os     = i_cfg.offset_bits[31];
        oe     = i_cfg.offset_bits[30:23];
        of     = i_cfg.offset_bits[22:0];
        px_nan = (pe == 8'hFF) && (pf != 23'd0);
        px_inf = (pe == 8'hFF) && (pf == 23'd0);
        of_nan = (oe == 8'hFF) && (of != 23'd0);
        of_inf = (oe == 8'hFF) && (of == 23'd0);
        bs_nan = (i_cfg.blank_bits[30:23] == 8'hFF) && (i_cfg.blank_bits[22:0] != 23'd0);
        eq     = (i_pixel_bits == i_cfg.blank_bits)
              || ((i_pixel_bits[30:0] == 31'd0) && (i_cfg.blank_bits[30:0] == 31'd0));

        n_s1.blank = px_nan || (i_cfg.blank_enable && !bs_nan && eq);

        a_px = i_pixel_bits[30:0] >= i_cfg.offset_bits[30:0];
        ea   = a_px ? pe : oe;
        eb   = a_px ? oe : pe;
        ma   = a_px ? {pe != 8'd0, pf} : {oe != 8'd0, of};
        mb   = a_px ? {oe != 8'd0, of} : {pe != 8'd0, pf};
        efa  = (ea == 8'd0) ? 8'd1 : ea;
        efb  = (eb == 8'd0) ? 8'd1 : eb;
        d    = efa - efb;
        xb   = {mb, 3'b000};
        if (d >= 8'd27) begin
            al = '0;
            st = |mb;
        end else begin
            al = xb >> d;
            st = |(xb & ~({27{1'b1}} << d));
        end

        n_s1.sub  = ps ^ os;
        n_s1.ef   = efa;
        n_s1.ma   = {ma, 3'b000};
        n_s1.mb   = al | {26'd0, st};
        n_s1.sign = a_px ? ps : os;
        priority if (of_nan || (px_inf && of_inf && (ps != os))) begin
            n_s1.cls = fpli_pkg::CL_NAN;
        end else if (px_inf) begin
            n_s1.cls  = fpli_pkg::CL_INF;
            n_s1.sign = ps;
        end else if (of_inf) begin
            n_s1.cls  = fpli_pkg::CL_INF;
            n_s1.sign = os;
        end else begin
            n_s1.cls = fpli_pkg::CL_FIN;
        end
    end

    // Stage 2: add or subtract the aligned significands
    always_comb begin
        n_s2.blank = r_s1.blank;
        n_s2.cls   = r_s1.cls;
        n_s2.sign  = r_s1.sign;
        n_s2.ef    = r_s1.ef;
        if (r_s1.sub) begin
            n_s2.sum = {1'b0, r_s1.ma} - {1'b0, r_s1.mb};
        end else begin
            n_s2.sum = {1'b0, r_s1.ma} + {1'b0, r_s1.mb};
        end
    end

    // Stage 3: normalise the sum, leading one to the top bit
    always_comb begin
        logic [4:0] lz;
        lz         = fpli_pkg::lzc28(r_s2.sum);
        n_s3.blank = r_s2.blank;
        n_s3.sign  = r_s2.sign;
        n_s3.norm  = r_s2.sum << lz;
        n_s3.e     = $signed({3'b000, r_s2.ef}) + 11'sd1 - $signed({6'd0, lz});
        if ((r_s2.cls == fpli_pkg::CL_FIN) && (r_s2.sum == 28'd0)) begin
            n_s3.cls = fpli_pkg::CL_ZERO;
        end else begin
            n_s3.cls = r_s2.cls;
        end
    end

    // Stage 4: round the sum to nearest even, unpack the gain, combine classes
    always_comb begin
        logic [24:0] m25;
        logic        up;
        logic [23:0] ms, mg_raw;
        t_exp        es, eg;
        fpli_pkg::t_class sc, gc;
        logic [7:0]  ge;
        logic [4:0]  lzg;
        up  = r_s3.norm[3] && ((|r_s3.norm[2:0]) || r_s3.norm[4]);
        m25 = {1'b0, r_s3.norm[27:4]} + {24'd0, up};
        if (m25[24]) begin
            ms = 24'h80_0000;
            es = r_s3.e + 11'sd1;
        end else begin
            ms = m25[23:0];
            es = r_s3.e;
        end
        sc = r_s3.cls;
        if ((sc == fpli_pkg::CL_FIN) && (es >= 11'sd255)) begin
            sc = fpli_pkg::CL_INF;
        end

        ge     = i_cfg.gain_bits[30:23];
        mg_raw = {ge != 8'd0, i_cfg.gain_bits[22:0]};
        lzg    = fpli_pkg::lzc24(mg_raw);
        eg     = $signed({3'b000, ((ge == 8'd0) ? 8'd1 : ge)}) - $signed({6'd0, lzg});
        priority if (ge == 8'hFF) begin
            gc = (i_cfg.gain_bits[22:0] != 23'd0) ? fpli_pkg::CL_NAN : fpli_pkg::CL_INF;
        end else if (i_cfg.gain_bits[30:0] == 31'd0) begin
            gc = fpli_pkg::CL_ZERO;
        end else begin
            gc = fpli_pkg::CL_FIN;
        end

        n_s4.blank = r_s3.blank;
        n_s4.sign  = r_s3.sign ^ i_cfg.gain_bits[31];
        n_s4.ms    = ms;
        n_s4.mg    = mg_raw << lzg;
        n_s4.e     = es + eg - 11'sd254;
        priority if ((sc == fpli_pkg::CL_NAN) || (gc == fpli_pkg::CL_NAN)
                     || ((sc == fpli_pkg::CL_ZERO) && (gc == fpli_pkg::CL_INF))
                     || ((sc == fpli_pkg::CL_INF) && (gc == fpli_pkg::CL_ZERO))) begin
            n_s4.cls = fpli_pkg::CL_NAN;
        end else if ((sc == fpli_pkg::CL_INF) || (gc == fpli_pkg::CL_INF)) begin
            n_s4.cls = fpli_pkg::CL_INF;
        end else if ((sc == fpli_pkg::CL_ZERO) || (gc == fpli_pkg::CL_ZERO)) begin
            n_s4.cls = fpli_pkg::CL_ZERO;
        end else begin
            n_s4.cls = fpli_pkg::CL_FIN;
        end
    end

    // Stage 5: multiply the significands
    always_comb begin
        n_s5.blank = r_s4.blank;
        n_s5.cls   = r_s4.cls;
        n_s5.sign  = r_s4.sign;
        n_s5.e     = r_s4.e;
        n_s5.prod  = r_s4.ms * r_s4.mg;
    end

    // Stage 6: normalise and round the product to nearest even
    always_comb begin
        logic [23:0] m;
        logic        rb, st, up;
        logic [24:0] m25;
        t_exp        e;
        if (r_s5.prod[47]) begin
            m  = r_s5.prod[47:24];
            rb = r_s5.prod[23];
            st = |r_s5.prod[22:0];
            e  = r_s5.e + 11'sd1;
        end else begin
            m  = r_s5.prod[46:23];
            rb = r_s5.prod[22];
            st = |r_s5.prod[21:0];
            e  = r_s5.e;
        end
        up  = rb && (st || m[0]);
        m25 = {1'b0, m} + {24'd0, up};
        n_s6.blank = r_s5.blank;
        n_s6.cls   = r_s5.cls;
        n_s6.sign  = r_s5.sign;
        if (m25[24]) begin
            n_s6.mant = 24'h80_0000;
            n_s6.e    = e + 11'sd1;
        end else begin
            n_s6.mant = m25[23:0];
            n_s6.e    = e;
        end
    end

    // Stage 7: round half away from zero and saturate to the index limits
    always_comb begin
        logic [3:0]  sh;
        logic [38:0] fx;
        logic [39:0] t;
        logic [15:0] mag;
        logic        sat;
        sh  = r_s6.e[3:0] + 4'd1;
        fx  = {15'd0, r_s6.mant} << sh;
        t   = {1'b0, fx} + 40'h80_0000;
        mag = t[39:24];
        // A magnitude that rounds up to 2^15 saturates as well
        sat = (r_s6.cls == fpli_pkg::CL_INF)
              || ((r_s6.cls == fpli_pkg::CL_FIN)
                  && ((r_s6.e >= 11'sd15) || ((r_s6.e >= -11'sd1) && mag[15])));
        priority if (r_s6.blank || (r_s6.cls == fpli_pkg::CL_NAN)) begin
            n_idx = fpli_pkg::BLANK_INDEX;
        end else if (sat) begin
            n_idx = r_s6.sign ? fpli_pkg::INDEX_MIN : fpli_pkg::INDEX_MAX;
        end else if ((r_s6.cls == fpli_pkg::CL_ZERO) || (r_s6.e < -11'sd1)) begin
            n_idx = '0;
        end else begin
            n_idx = r_s6.sign ? -$signed(mag) : $signed(mag);
        end
    end

    // Hold valid bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 7; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (en[1]) r_s1  <= n_s1;
        if (en[2]) r_s2  <= n_s2;
        if (en[3]) r_s3  <= n_s3;
        if (en[4]) r_s4  <= n_s4;
        if (en[5]) r_s5  <= n_s5;
        if (en[6]) r_s6  <= n_s6;
        if (en[7]) r_idx <= n_idx;
    end

    // Input only stalls when every stage holds a word
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // A stage that cannot advance keeps its word
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && !en[3]) |=> (r_v[3] && $stable(r_s3)))
        else $error("stalled stage 3 word changed");

    // A finite rounded sum and the unpacked gain both carry their leading one
    a_sum_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !r_s4.blank && (r_s4.cls == fpli_pkg::CL_FIN)) |-> (r_s4.ms[23] && r_s4.mg[23]))
        else $error("unnormalised operand at multiplier");

    // The blank code only comes from a blank pixel or a NaN
    a_blank_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && en[7] && !r_s6.blank && (r_s6.cls != fpli_pkg::CL_NAN))
        |=> (r_idx != fpli_pkg::BLANK_INDEX))
        else $error("blank code from an ordinary pixel");

endmodule

/* rtl/float_pixel_to_lookup_index.sv */
// Top level: configuration registers and the pixel to lookup index pipeline.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+------------------------------
//  pixel in | i_pixel_valid | o_pixel_ready | i_pixel_bits[31:0]
//  index out| o_lut_valid   | i_lut_ready   | o_lut_index[15:0] signed
//  config   | i_cfg_valid   | o_cfg_ready   | i_cfg_index[7:0], i_cfg_data[31:0]
//
// One word per cycle sustained while i_lut_ready is high; an accepted word passes through the seven
// register stages (align, add, normalise, round, multiply, round, convert) before o_lut_valid rises.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
// A stalled output holds its word; upstream stages keep filling bubbles until all are full.
// The configuration port is always ready.
module float_pixel_to_lookup_index (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_ready,
    input  logic [fpli_pkg::WORD_W-1:0]         i_pixel_bits,
    output logic                                o_lut_valid,
    input  logic                                i_lut_ready,
    output logic signed [fpli_pkg::INDEX_W-1:0] o_lut_index,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpli_pkg::WORD_W-1:0]         i_cfg_data
);

    fpli_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits  <= '0;
            r_cfg.gain_bits    <= fpli_pkg::GAIN_RESET;
            r_cfg.blank_enable <= 1'b0;
            r_cfg.blank_bits   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpli_pkg::CFG_OFFSET:   r_cfg.offset_bits  <= i_cfg_data;
                fpli_pkg::CFG_GAIN:     r_cfg.gain_bits    <= i_cfg_data;
                fpli_pkg::CFG_BLANK_EN: r_cfg.blank_enable <= i_cfg_data[0];
                fpli_pkg::CFG_BLANK:    r_cfg.blank_bits   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fpli_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_pixel_valid),
        .o_ready      (o_pixel_ready),
        .i_pixel_bits (i_pixel_bits),
        .o_valid      (o_lut_valid),
        .i_ready      (i_lut_ready),
        .o_lut_index  (o_lut_index)
    );

endmodule
